// ===== src/mdgfm_pkg.sv =====
// ============================================================================
// mdgfm_pkg
// Shared types, constants and the face table for the dual-graph face matcher.
// ============================================================================
package mdgfm_pkg;

  localparam int NODE_W = 32;
  localparam int ELEM_W = 20;
  localparam int COUNT_W = 24;
  localparam int FACE_SLOTS = 20;

  localparam logic [3:0] TYPE_TETRA   = 4'd10;
  localparam logic [3:0] TYPE_HEXA    = 4'd11;
  localparam logic [3:0] TYPE_PRISM   = 4'd13;
  localparam logic [3:0] TYPE_PYRAMID = 4'd14;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  localparam logic [63:0] HASH_M0 = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] HASH_M1 = 64'hC2B2AE3D27D4EB4F;
  localparam logic [63:0] HASH_M2 = 64'h165667B19E3779F9;
  localparam logic [63:0] HASH_M3 = 64'hBF58476D1CE4E5B9;

  typedef struct packed {
    logic [3:0]        kind;
    logic [NODE_W-1:0] node_0;
    logic [NODE_W-1:0] node_1;
    logic [NODE_W-1:0] node_2;
    logic [NODE_W-1:0] node_3;
    logic [NODE_W-1:0] node_4;
    logic [NODE_W-1:0] node_5;
    logic [NODE_W-1:0] node_6;
    logic [NODE_W-1:0] node_7;
  } elem_in_t;

  typedef struct packed {
    logic [ELEM_W-1:0]  first_element;
    logic [ELEM_W-1:0]  second_element;
    logic [COUNT_W-1:0] edge_total;
    logic               table_full;
    logic               last;
  } match_out_t;

  // One classified face: sorted distinct ids, padded with zero.
  typedef struct packed {
    logic [63:0]       lo;
    logic [63:0]       hi;
    logic [2:0]        size;
    logic [ELEM_W-1:0] elem;
    logic              last;
  } face_t;

  // Node selects for each face slot, packed as four 3-bit picks.
  function automatic logic [11:0] face_pick(input logic [4:0] idx);
    logic [11:0] r;
    begin
      case (idx)
        5'd0:  r = {3'd0, 3'd2, 3'd1, 3'd0};
        5'd1:  r = {3'd0, 3'd3, 3'd2, 3'd1};
        5'd2:  r = {3'd0, 3'd0, 3'd3, 3'd2};
        5'd3:  r = {3'd0, 3'd1, 3'd0, 3'd3};
        5'd4:  r = {3'd2, 3'd3, 3'd1, 3'd0};
        5'd5:  r = {3'd3, 3'd7, 3'd5, 3'd1};
        5'd6:  r = {3'd6, 3'd7, 3'd3, 3'd2};
        5'd7:  r = {3'd6, 3'd7, 3'd5, 3'd4};
        5'd8:  r = {3'd4, 3'd6, 3'd2, 3'd0};
        5'd9:  r = {3'd4, 3'd5, 3'd1, 3'd0};
        5'd10: r = {3'd3, 3'd4, 3'd1, 3'd0};
        5'd11: r = {3'd0, 3'd0, 3'd2, 3'd1};
        5'd12: r = {3'd2, 3'd5, 3'd4, 3'd1};
        5'd13: r = {3'd2, 3'd5, 3'd3, 3'd0};
        5'd14: r = {3'd0, 3'd5, 3'd4, 3'd3};
        5'd15: r = {3'd3, 3'd2, 3'd1, 3'd0};
        5'd16: r = {3'd0, 3'd4, 3'd2, 3'd1};
        5'd17: r = {3'd0, 3'd4, 3'd3, 3'd0};
        5'd18: r = {3'd0, 3'd4, 3'd1, 3'd0};
        5'd19: r = {3'd0, 3'd4, 3'd3, 3'd2};
        default: r = '0;
      endcase
      return r;
    end
  endfunction

  function automatic logic face_quad(input logic [4:0] idx);
    begin
      case (idx) inside
        5'd4, 5'd5, 5'd6, 5'd7, 5'd8, 5'd9, 5'd10, 5'd12, 5'd13, 5'd15: return 1'b1;
        default: return 1'b0;
      endcase
    end
  endfunction

endpackage

// ===== src/mdgfm_front.sv =====
// ============================================================================
// mdgfm_front
// Accepts elements, walks their faces one a cycle unless the queue is full,
// sorts and de-duplicates each face key and pushes it to the face queue.
// ============================================================================
module mdgfm_front
  import mdgfm_pkg::*;
#(
  parameter int NODE_ID_BITS = 32,
  parameter int ELEMENT_INDEX_BITS = 20
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  elem_in_t elem,
  output logic     busy,
  output logic     push,
  output face_t    face,
  input  logic     full
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_WALK = 2'b10
  } fstate_t;

  fstate_t state;
  elem_in_t held;
  logic [4:0] idx;
  logic [4:0] stop;
  logic [ELEMENT_INDEX_BITS-1:0] counter;
  logic [ELEMENT_INDEX_BITS-1:0] cur;

  logic [NODE_W-1:0] nodes [8];
  logic [NODE_W-1:0] v [4];
  logic [NODE_W-1:0] k [4];
  logic [11:0] pick;
  logic [2:0] len;
  logic [NODE_W-1:0] nmask;
  logic [4:0] start_idx;
  logic [4:0] cnt;
  logic [2:0] sz;
  logic dup;
  logic [NODE_W-1:0] tmp;

  assign nmask = (NODE_ID_BITS >= 32) ? '1 : NODE_W'((64'd1 << NODE_ID_BITS) - 64'd1);

  always_comb begin
    unique case (elem.kind)
      TYPE_TETRA:   begin start_idx = 5'd0;  cnt = 5'd4; end
      TYPE_HEXA:    begin start_idx = 5'd4;  cnt = 5'd6; end
      TYPE_PRISM:   begin start_idx = 5'd10; cnt = 5'd5; end
      TYPE_PYRAMID: begin start_idx = 5'd15; cnt = 5'd5; end
      default:      begin start_idx = 5'd0;  cnt = 5'd0; end
    endcase
  end

  assign busy = (state != S_IDLE);

  // Build the sorted distinct key by insertion over up to four ids.
  always_comb begin
    nodes[0] = held.node_0; nodes[1] = held.node_1;
    nodes[2] = held.node_2; nodes[3] = held.node_3;
    nodes[4] = held.node_4; nodes[5] = held.node_5;
    nodes[6] = held.node_6; nodes[7] = held.node_7;
    pick = face_pick(idx);
    len = face_quad(idx) ? 3'd4 : 3'd3;
    dup = 1'b0;
    tmp = '0;
    for (int i = 0; i < 4; i++) begin
      v[i] = nodes[pick[3*i +: 3]] & nmask;
      k[i] = '0;
    end
    sz = 3'd0;
    for (int i = 0; i < 4; i++) begin
      if (3'(i) < len) begin
        dup = 1'b0;
        for (int j = 0; j < 4; j++) begin
          if (3'(j) < sz && k[j] == v[i]) dup = 1'b1;
        end
        if (!dup) begin
          tmp = v[i];
          for (int j = 0; j < 4; j++) begin
            if (3'(j) < sz && k[j] > tmp) begin
              {k[j], tmp} = {tmp, k[j]};
            end
          end
          k[sz[1:0]] = tmp;
          sz = sz + 3'd1;
        end
      end
    end
    face.lo = {k[1], k[0]};
    face.hi = {k[3], k[2]};
    face.size = sz;
    face.elem = ELEM_W'(cur);
    face.last = (idx + 5'd1 == stop);
  end

  assign push = (state == S_WALK) && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      counter <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            held <= elem;
            idx <= start_idx;
            stop <= start_idx + cnt;
            cur <= counter;
            counter <= counter + 1'b1;
            if (cnt != 5'd0) state <= S_WALK;
          end
        end
        S_WALK: begin
          if (!full) begin
            idx <= idx + 5'd1;
            if (idx + 5'd1 == stop) state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== src/mdgfm_fifo.sv =====
// ============================================================================
// mdgfm_fifo
// Short face queue between the classifier and the table engine.
// ============================================================================
module mdgfm_fifo
  import mdgfm_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  face_t wdata,
  output logic  full,
  input  logic  pop,
  output face_t rdata,
  output logic  empty
);

  face_t mem [4];
  logic [1:0] wp, rp;
  logic [2:0] fill;

  assign full = (fill == 3'd4);
  assign empty = (fill == 3'd0);
  assign rdata = mem[rp];

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      fill <= '0;
    end else begin
      if (push) wp <= wp + 2'd1;
      if (pop) rp <= rp + 2'd1;
      fill <= fill + {2'b0, push} - {2'b0, pop};
    end
  end

endmodule

// ===== src/mdgfm_back.sv =====
// ============================================================================
// mdgfm_back
// Hashes each face key, probes the face table linearly and emits matches and
// table-full results. The hash runs on one 32x32 multiplier. The table sits in
// one memory; valid bits are cleared by a sweep after reset. Each emitted
// result waits one slot so that the final one of an element carries last.
// ============================================================================
module mdgfm_back
  import mdgfm_pkg::*;
#(
  parameter int FACE_TABLE_DEPTH = 4096,
  parameter int MAX_PROBES = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       empty,
  input  face_t      face,
  output logic       pop,
  output logic       idle,
  output logic       done,
  output match_out_t result
);

  localparam int AW = (FACE_TABLE_DEPTH > 1) ? $clog2(FACE_TABLE_DEPTH) : 1;
  localparam int PW = $clog2(MAX_PROBES + 1);

  typedef struct packed {
    logic              valid;
    logic [63:0]       lo;
    logic [63:0]       hi;
    logic [2:0]        size;
    logic [ELEM_W-1:0] owner;
  } entry_t;

  typedef enum logic [6:0] {
    B_CLEAR = 7'b0000001,
    B_IDLE  = 7'b0000010,
    B_HASH  = 7'b0000100,
    B_READ  = 7'b0001000,
    B_WAIT  = 7'b0010000,
    B_CHECK = 7'b0100000,
    B_FLUSH = 7'b1000000
  } bstate_t;

  bstate_t state;
  entry_t table_mem [FACE_TABLE_DEPTH];
  entry_t rd;
  face_t cur;
  match_out_t pend;
  logic pend_valid;
  logic [63:0] acc, x, acc_sum, prod, size_mul;
  logic [31:0] mul_a, mul_b;
  logic [3:0] hstep;
  logic [AW-1:0] slot, clr_addr;
  logic [PW-1:0] probe;
  logic [COUNT_W-1:0] count, count_inc;
  logic we;
  entry_t wd;
  logic [AW-1:0] waddr;
  logic hit;

  assign idle = (state == B_IDLE) && empty;
  assign pop = (state == B_IDLE) && !empty;
  assign hit = rd.lo == cur.lo && rd.hi == cur.hi && rd.size == cur.size;
  assign count_inc = (count == COUNT_MAX) ? count : count + 1'b1;

  // Size term of the hash: the size is only three bits wide.
  assign size_mul = ({64{face.size[0]}} & HASH_M2) + ({64{face.size[1]}} & (HASH_M2 << 1))
                  + ({64{face.size[2]}} & (HASH_M2 << 2));

  // Each 64-bit product mod 2^64 takes three partial products: low x low,
  // then the low halves of both cross terms shifted up.
  always_comb begin
    case (hstep)
      4'd0:    begin mul_a = cur.lo[31:0];  mul_b = HASH_M0[31:0];  end
      4'd1:    begin mul_a = cur.lo[31:0];  mul_b = HASH_M0[63:32]; end
      4'd2:    begin mul_a = cur.lo[63:32]; mul_b = HASH_M0[31:0];  end
      4'd3:    begin mul_a = cur.hi[31:0];  mul_b = HASH_M1[31:0];  end
      4'd4:    begin mul_a = cur.hi[31:0];  mul_b = HASH_M1[63:32]; end
      4'd5:    begin mul_a = cur.hi[63:32]; mul_b = HASH_M1[31:0];  end
      4'd7:    begin mul_a = x[31:0];       mul_b = HASH_M3[31:0];  end
      4'd8:    begin mul_a = x[31:0];       mul_b = HASH_M3[63:32]; end
      4'd9:    begin mul_a = x[63:32];      mul_b = HASH_M3[31:0];  end
      default: begin mul_a = '0;            mul_b = '0;             end
    endcase
  end

  assign prod = mul_a * mul_b;
  assign acc_sum = acc + {prod[31:0], 32'b0};

  always_comb begin
    we = 1'b0;
    waddr = slot;
    wd = '{valid: 1'b1, lo: cur.lo, hi: cur.hi, size: cur.size, owner: cur.elem};
    if (state == B_CLEAR) begin
      we = 1'b1;
      waddr = clr_addr;
      wd = '0;
    end else if (state == B_CHECK && !rd.valid) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) table_mem[waddr] <= wd;
    rd <= table_mem[slot];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_CLEAR;
      clr_addr <= '0;
      count <= '0;
      done <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      unique case (state)
        B_CLEAR: begin
          done <= 1'b0;
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(FACE_TABLE_DEPTH - 1)) state <= B_IDLE;
        end
        B_IDLE: begin
          done <= 1'b0;
          if (!empty) begin
            cur <= face;
            x <= size_mul;
            hstep <= 4'd0;
            state <= B_HASH;
          end
        end
        B_HASH: begin
          done <= 1'b0;
          hstep <= hstep + 4'd1;
          case (hstep) inside
            4'd0, 4'd3, 4'd7: acc <= prod;
            4'd2, 4'd5:       x <= x ^ acc_sum;
            4'd6:             x <= x ^ (x >> 29);
            4'd9: begin
              slot <= AW'(acc_sum ^ (acc_sum >> 32));
              probe <= '0;
              state <= B_READ;
            end
            default:          acc <= acc_sum;
          endcase
        end
        B_READ: begin
          done <= 1'b0;
          state <= B_WAIT;
        end
        B_WAIT: begin
          done <= 1'b0;
          state <= B_CHECK;
        end
        B_CHECK: begin
          if (!rd.valid || hit || probe == PW'(MAX_PROBES - 1)) begin
            state <= cur.last ? B_FLUSH : B_IDLE;
            done <= rd.valid && pend_valid;
            // A match or a full table yields a result; hold it back one slot.
            if (rd.valid) begin
              if (pend_valid) result <= pend;
              pend <= '{first_element: hit ? rd.owner : '0,
                        second_element: cur.elem,
                        edge_total: hit ? count_inc : count,
                        table_full: !hit,
                        last: 1'b0};
              pend_valid <= 1'b1;
              if (hit) count <= count_inc;
            end
          end else begin
            done <= 1'b0;
            probe <= probe + 1'b1;
            slot <= slot + 1'b1;
            state <= B_READ;
          end
        end
        B_FLUSH: begin
          done <= pend_valid;
          if (pend_valid) begin
            result <= '{first_element: pend.first_element,
                        second_element: pend.second_element,
                        edge_total: pend.edge_total,
                        table_full: pend.table_full,
                        last: 1'b1};
          end
          pend_valid <= 1'b0;
          state <= B_IDLE;
        end
        default: begin
          done <= 1'b0;
          state <= B_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== src/mesh_dual_graph_face_matcher.sv =====
// ============================================================================
// mesh_dual_graph_face_matcher
// Matches shared faces of mesh elements through a hashed face table.
// ============================================================================
// channel  signals                  transaction
// in       start, busy, element     start && !busy
// out      result_valid, result     result_valid, one cycle, no back pressure
//
// One element at a time: busy stays high until its last face has left the
// table engine. Each face passes queue pop, hash, read, wait and check,
// with read, wait and check again for each extra probe; a faceless element
// is taken without the front leaving idle.
// After reset a clearing pass over the whole face table holds busy high.
// Results cannot be held off; the final result of an element is held back
// in pend and leaves from the flush state, marked by last.
module mesh_dual_graph_face_matcher
  import mdgfm_pkg::*;
#(
  parameter int FACE_TABLE_DEPTH = 4096,
  parameter int NODE_ID_BITS = 32,
  parameter int ELEMENT_INDEX_BITS = 20,
  parameter int MAX_PROBES = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  elem_in_t   element,
  output logic       result_valid,
  output match_out_t result
);

  logic f_busy, push, full, pop, empty, idle, done;
  face_t wface, rface;
  match_out_t bres;

  mdgfm_front #(
    .NODE_ID_BITS(NODE_ID_BITS), .ELEMENT_INDEX_BITS(ELEMENT_INDEX_BITS)
  ) u_front (
    .clk, .rst, .start(start && !busy), .elem(element), .busy(f_busy),
    .push, .face(wface), .full
  );

  mdgfm_fifo u_fifo (
    .clk, .rst, .push, .wdata(wface), .full, .pop, .rdata(rface), .empty
  );

  mdgfm_back #(
    .FACE_TABLE_DEPTH(FACE_TABLE_DEPTH), .MAX_PROBES(MAX_PROBES)
  ) u_back (
    .clk, .rst, .empty, .face(rface), .pop, .idle, .done, .result(bres)
  );

  // One element at a time: hold off until the engine has drained.
  assign busy = f_busy || !idle;

  assign result_valid = done;
  assign result = bres;

endmodule

// ===== tb/tb_mesh_dual_graph_face_matcher.sv =====
// ----------------------------------------------------------------------------
// Dual-graph face matcher testbench
// Sends mesh elements through the start/busy port and keeps its own copy of
// the hashed face table to work out each shared-face result. Every result
// strobe is checked field by field against the oldest expected result.
// ----------------------------------------------------------------------------
module tb_mesh_dual_graph_face_matcher
  import mdgfm_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 4096;
  localparam int PROBES = 8;
  localparam int STALL_LIMIT = 30000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  elem_in_t element = '0;
  logic result_valid;
  match_out_t result;

  mesh_dual_graph_face_matcher uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .element(element),
    .result_valid(result_valid), .result(result)
  );

  always #5 clk = ~clk;

  // Face corner picks and sizes per face slot.
  byte unsigned corner_pick [20][4] = '{
    '{0,1,2,0}, '{1,2,3,0}, '{2,3,0,0}, '{3,0,1,0},
    '{0,1,3,2}, '{1,5,7,3}, '{2,3,7,6}, '{4,5,7,6}, '{0,2,6,4}, '{0,1,5,4},
    '{0,1,4,3}, '{1,2,0,0}, '{1,4,5,2}, '{0,3,5,2}, '{3,4,5,0},
    '{0,1,2,3}, '{1,2,4,0}, '{0,3,4,0}, '{0,1,4,0}, '{2,3,4,0}};
  byte unsigned corner_count [20] = '{3,3,3,3, 4,4,4,4,4,4, 4,3,4,4,3, 4,3,3,3,3};

  // Mirror of the face table.
  bit [63:0] slot_lo [DEPTH];
  bit [63:0] slot_hi [DEPTH];
  bit [2:0] slot_size [DEPTH];
  bit [ELEM_W-1:0] slot_owner [DEPTH];
  bit slot_used [DEPTH];
  bit [ELEM_W-1:0] next_elem = '0;
  bit [COUNT_W-1:0] pair_count = '0;

  elem_in_t pending_elems[$];
  match_out_t expected_pairs[$];

  int errors = 0;
  int elems_sent = 0;
  int pairs_seen = 0;
  int full_seen = 0;
  int stall_cycles = 0;
  bit took_elem = 1'b0;

  function automatic bit [11:0] face_bucket(bit [63:0] lo, bit [63:0] hi, int sz);
    bit [63:0] h;
    h = lo * HASH_M0;
    h ^= hi * HASH_M1;
    h ^= 64'(sz) * HASH_M2;
    h ^= h >> 29;
    h *= HASH_M3;
    h ^= h >> 32;
    return h[11:0];
  endfunction

  function automatic bit [31:0] node_of(elem_in_t e, int k);
    case (k)
      0: return e.node_0;
      1: return e.node_1;
      2: return e.node_2;
      3: return e.node_3;
      4: return e.node_4;
      5: return e.node_5;
      6: return e.node_6;
      default: return e.node_7;
    endcase
  endfunction

  task automatic queue_elem(elem_in_t e);
    pending_elems.insert(pending_elems.size(), e);
  endtask

  task automatic match_faces(elem_in_t e);
    int first_slot, nfaces, sz, j, n_before;
    bit [31:0] ids [4];
    bit [31:0] v;
    bit [63:0] lo, hi;
    bit [11:0] b, s;
    bit dup, done;
    match_out_t r;
    bit [ELEM_W-1:0] me;
    me = next_elem;
    next_elem++;
    n_before = expected_pairs.size();
    case (e.kind)
      TYPE_TETRA:   begin first_slot = 0;  nfaces = 4; end
      TYPE_HEXA:    begin first_slot = 4;  nfaces = 6; end
      TYPE_PRISM:   begin first_slot = 10; nfaces = 5; end
      TYPE_PYRAMID: begin first_slot = 15; nfaces = 5; end
      default:      begin first_slot = 0;  nfaces = 0; end
    endcase
    for (int f = first_slot; f < first_slot + nfaces; f++) begin
      ids = '{0, 0, 0, 0};
      sz = 0;
      for (int i = 0; i < corner_count[f]; i++) begin
        v = node_of(e, corner_pick[f][i]);
        dup = 1'b0;
        for (int k = 0; k < sz; k++) if (ids[k] == v) dup = 1'b1;
        if (!dup) begin
          j = sz;
          while (j > 0 && ids[j-1] > v) begin
            ids[j] = ids[j-1];
            j--;
          end
          ids[j] = v;
          sz++;
        end
      end
      lo = {ids[1], ids[0]};
      hi = {ids[3], ids[2]};
      b = face_bucket(lo, hi, sz);
      done = 1'b0;
      for (int p = 0; p < PROBES && !done; p++) begin
        s = b + 12'(p);
        if (!slot_used[s]) begin
          slot_used[s] = 1'b1;
          slot_lo[s] = lo;
          slot_hi[s] = hi;
          slot_size[s] = 3'(sz);
          slot_owner[s] = me;
          done = 1'b1;
        end else if (slot_lo[s] == lo && slot_hi[s] == hi && slot_size[s] == 3'(sz)) begin
          if (pair_count != COUNT_MAX) pair_count++;
          r = '{first_element: slot_owner[s], second_element: me,
                edge_total: pair_count, table_full: 1'b0, last: 1'b0};
          expected_pairs.insert(expected_pairs.size(), r);
          done = 1'b1;
        end
      end
      if (!done) begin
        r = '{first_element: '0, second_element: me, edge_total: pair_count,
              table_full: 1'b1, last: 1'b0};
        expected_pairs.insert(expected_pairs.size(), r);
      end
    end
    if (expected_pairs.size() > n_before)
      expected_pairs[expected_pairs.size()-1].last = 1'b1;
  endtask

  // Accept transactions and check results on the rising edge.
  always @(posedge clk) begin
    match_out_t want;
    bit took, seen;
    took = !rst && start && !busy;
    seen = !rst && result_valid;
    took_elem <= took;
    if (seen) begin
      pairs_seen <= pairs_seen + 1;
      if (result.table_full) full_seen <= full_seen + 1;
      if (expected_pairs.size() == 0) begin
        $display("%0t: unexpected result %p", $time, result);
        errors <= errors + 1;
      end else begin
        want = expected_pairs.pop_front();
        if (result !== want) begin
          $display("%0t: mismatch expected %p actual %p", $time, want, result);
          errors <= errors + 1;
        end
      end
    end
    if (took) begin
      match_faces(element);
      elems_sent <= elems_sent + 1;
    end
    if (rst || took || seen) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("Verification failed");
      $finish;
    end
  end

  // Driver: advance to the next element once the current one is taken.
  always @(negedge clk) begin
    logic go;
    elem_in_t nxt;
    go = start;
    nxt = element;
    if (!rst && (!start || took_elem)) begin
      go = 1'b0;
      if (pending_elems.size() > 0 &&
          ((elems_sent > 100 && elems_sent < 180) || $urandom_range(99) >= 14)) begin
        nxt = pending_elems.pop_front();
        go = 1'b1;
      end
    end
    start <= go;
    element <= nxt;
  end

  function automatic elem_in_t mesh_elem(logic [3:0] t, bit [31:0] pool[$]);
    elem_in_t e;
    e.kind = t;
    e.node_0 = pool[$urandom_range(pool.size()-1)];
    e.node_1 = pool[$urandom_range(pool.size()-1)];
    e.node_2 = pool[$urandom_range(pool.size()-1)];
    e.node_3 = pool[$urandom_range(pool.size()-1)];
    e.node_4 = pool[$urandom_range(pool.size()-1)];
    e.node_5 = pool[$urandom_range(pool.size()-1)];
    e.node_6 = pool[$urandom_range(pool.size()-1)];
    e.node_7 = pool[$urandom_range(pool.size()-1)];
    return e;
  endfunction

  function automatic elem_in_t wild_elem();
    elem_in_t e;
    e.kind = 4'($urandom_range(15));
    e.node_0 = $urandom();
    e.node_1 = $urandom();
    e.node_2 = $urandom();
    e.node_3 = $urandom();
    e.node_4 = $urandom();
    e.node_5 = $urandom();
    e.node_6 = $urandom();
    e.node_7 = $urandom();
    return e;
  endfunction

  function automatic elem_in_t flat_elem(logic [3:0] t, bit [31:0] v);
    return '{t, v, v, v, v, v, v, v, v};
  endfunction

  initial begin
    bit [31:0] pool[$];
    bit [31:0] v;
    logic [3:0] kinds [4];
    int found;
    elem_in_t e;
    kinds = '{TYPE_TETRA, TYPE_HEXA, TYPE_PRISM, TYPE_PYRAMID};

    // Directed: each type twice so faces match, extremes, faceless codes.
    queue_elem('{TYPE_TETRA, 32'd0, 32'd1, 32'd2, 32'hFFFFFFFF, 0, 0, 0, 0});
    queue_elem('{TYPE_TETRA, 32'hFFFFFFFF, 32'd2, 32'd1, 32'd5, 0, 0, 0, 0});
    queue_elem('{TYPE_HEXA, 1, 2, 3, 4, 5, 6, 7, 8});
    queue_elem('{TYPE_HEXA, 5, 6, 7, 8, 9, 10, 11, 12});
    queue_elem('{TYPE_PRISM, 20, 21, 22, 23, 24, 25, 0, 0});
    queue_elem('{TYPE_PRISM, 23, 24, 25, 26, 27, 28, 0, 0});
    queue_elem('{TYPE_PYRAMID, 1, 2, 4, 3, 30, 0, 0, 0});
    queue_elem('{TYPE_PYRAMID, 1, 2, 4, 3, 30, 0, 0, 0});
    // Degenerate elements: the faces of each collapse to one key and match that element itself.
    queue_elem(flat_elem(TYPE_HEXA, 32'hFFFFFFFF));
    queue_elem(flat_elem(TYPE_PRISM, 32'h0));
    for (int t = 0; t < 16; t++)
      if (t != TYPE_TETRA && t != TYPE_HEXA && t != TYPE_PRISM && t != TYPE_PYRAMID)
        queue_elem('{4'(t), 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hAAAAAAAA, 0, 0, 0, 0, 0});
    // Table full: nine single-node keys that hash to one bucket overflow the probes.
    found = 0;
    while (found < 9) begin
      v = $urandom();
      if (face_bucket({32'd0, v}, 64'd0, 1) == 12'h5A5) begin
        queue_elem(flat_elem(TYPE_TETRA, v));
        found++;
      end
    end

    // Random: mostly elements over a small node pool so faces get shared.
    for (int i = 0; i < 270; i++) begin
      if (i % 60 == 0) begin
        pool.delete();
        for (int k = 0; k < 10; k++) pool.insert(pool.size(), $urandom());
      end
      if ($urandom_range(99) < 80) begin
        e = mesh_elem(kinds[$urandom_range(3)], pool);
      end else begin
        e = wild_elem();
      end
      queue_elem(e);
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_elems.size() > 0 || start || expected_pairs.size() > 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Sent %0d elements, checked %0d results (%0d with the table full flag).",
             elems_sent, pairs_seen, full_seen);
    if (errors == 0 && expected_pairs.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
